// ===== design/wfba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants for the worst-fit block allocator: beat
// structs, function codes, default sizing and the scan unit control group.
// ----------------------------------------------------------------------------
package wfba_pkg;

    localparam int DEF_BLOCKS    = 16;
    localparam int DEF_SIZE_BITS = 16;

    localparam int AMT_W  = 16;
    localparam int SLOT_W = 4;
    localparam int REQ_W  = 16;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_REQ  = 1'b1;

    typedef struct packed {
        logic             func;
        logic [AMT_W-1:0] amount;
    } t_in_beat;

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  granted_size;
        logic [REQ_W-1:0]  request_number;
    } t_res_beat;

    typedef struct packed {
        logic clear;
        logic cand_vld;
    } t_scan_ctl;

endpackage
`default_nettype wire

// ===== design/wfba_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_scan
// Shared compare unit: one table entry per cycle while cand_vld is set; it
// keeps the largest free size seen so far with its slot, lowest slot on tie.
// ----------------------------------------------------------------------------
module wfba_scan #(
    parameter int SIZE_BITS = wfba_pkg::DEF_SIZE_BITS,
    parameter int IDX_W     = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wfba_pkg::t_scan_ctl     i_ctl,
    input  wire     [SIZE_BITS-1:0] i_cand_size,
    input  wire     [IDX_W-1:0]     i_cand_idx,
    output logic                    o_found,
    output logic    [SIZE_BITS-1:0] o_best_size,
    output logic    [IDX_W-1:0]     o_best_idx
);
    import wfba_pkg::*;

    logic                 r_found;
    logic [SIZE_BITS-1:0] r_best_size;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 take;

    // strict greater keeps the earlier slot on equal sizes
    assign take = i_ctl.cand_vld && (!r_found || (i_cand_size > r_best_size));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_best_size <= i_cand_size;
            r_best_idx  <= i_cand_idx;
        end
    end

    assign o_found     = r_found;
    assign o_best_size = r_best_size;
    assign o_best_idx  = r_best_idx;

endmodule
`default_nettype wire

// ===== design/worst_fit_block_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Table of memory blocks; loads append a block while the table has room,
// requests take the largest free block if it fits.
//
//   channel   signals                     direction  handshake
//   command   start, busy, i_in           in         start && !busy
//   result    o_valid, o_res              out        o_valid, one cycle
//
// A load never raises busy; its result beat shows in the cycle after accept.
// A request with blocks loaded keeps busy high through the scan (one read of
// the size memory per loaded block through the one compare unit), one drain
// and one decision; with no block loaded it answers next cycle, not busy.
// Synchronous reset clears the used marks and counters; no clearing pass.
// The receiver cannot stall: each result beat is valid for one cycle.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator #(
    parameter int BLOCKS    = wfba_pkg::DEF_BLOCKS,
    parameter int SIZE_BITS = wfba_pkg::DEF_SIZE_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wfba_pkg::t_in_beat   i_in,
    output logic                 o_valid,
    output wfba_pkg::t_res_beat  o_res
);
    import wfba_pkg::*;

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_loaded;
    logic [REQ_W-1:0]     r_req;
    logic [BLOCKS-1:0]    r_used;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic [AMT_W-1:0]     r_amount;
    logic                 r_valid;
    t_res_beat            r_res;

    logic [SIZE_BITS-1:0] mem [BLOCKS];

    logic                 accept;
    logic                 full;
    logic                 last_idx;
    logic                 fits;
    t_scan_ctl            scan_ctl;
    logic                 found;
    logic [SIZE_BITS-1:0] best_size;
    logic [IDX_W-1:0]     best_idx;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_loaded == CNT_W'(BLOCKS));
    assign last_idx = (CNT_W'(r_idx) == (r_loaded - CNT_W'(1)));
    assign fits     = found && (CMP_W'(best_size) >= CMP_W'(r_amount));

    assign scan_ctl.clear    = accept && (i_in.func == FUNC_REQ);
    assign scan_ctl.cand_vld = r_cmp_vld && !r_used[r_cmp_idx];

    wfba_scan #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_cand_size (r_rd_data),
        .i_cand_idx  (r_cmp_idx),
        .o_found     (found),
        .o_best_size (best_size),
        .o_best_idx  (best_idx)
    );

    // size memory: one write port for loads, one registered read for the scan
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.func == FUNC_LOAD) && !full) begin
            mem[r_loaded[IDX_W-1:0]] <= SIZE_BITS'(i_in.amount);
        end
        r_rd_data <= mem[r_idx];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_in.func == FUNC_REQ) && (r_loaded != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_loaded  <= '0;
            r_req     <= '0;
            r_used    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= 1'b0;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (accept) begin
                r_idx <= '0;
                if (i_in.func == FUNC_LOAD) begin
                    r_valid <= 1'b1;
                    if (!full) begin
                        r_loaded                     <= r_loaded + CNT_W'(1);
                        r_used[r_loaded[IDX_W-1:0]] <= 1'b0;
                    end
                end else begin
                    r_req <= r_req + REQ_W'(1);
                    // nothing loaded: refuse without a scan
                    if (r_loaded == '0) begin
                        r_valid <= 1'b1;
                    end
                end
            end
            if ((r_state == ST_SCAN) && !last_idx) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_state == ST_DECIDE) begin
                r_valid <= 1'b1;
                if (fits) begin
                    r_used[best_idx] <= 1'b1;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_amount <= i_in.amount;
            r_cmp_idx <= '0;
            if (i_in.func == FUNC_LOAD) begin
                r_res.accepted       <= !full;
                r_res.slot           <= full ? '0 : SLOT_W'(r_loaded);
                r_res.granted_size   <= '0;
                r_res.request_number <= r_req;
            end else begin
                r_res.accepted       <= 1'b0;
                r_res.slot           <= '0;
                r_res.granted_size   <= '0;
                r_res.request_number <= r_req + REQ_W'(1);
            end
        end else begin
            if (r_state == ST_SCAN) begin
                r_cmp_idx <= r_idx;
            end
            if (r_state == ST_DECIDE) begin
                r_res.accepted     <= fits;
                r_res.slot         <= fits ? SLOT_W'(best_idx) : '0;
                r_res.granted_size <= fits ? AMT_W'(best_size) : '0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // a request with blocks loaded must hold off the next command
    a_req_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.func == FUNC_REQ) && (r_loaded != '0)) |=> busy)
        else $error("request scan did not raise busy");

    // a refused beat carries no slot and no size
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.accepted) |->
            ((o_res.slot == '0) && (o_res.granted_size == '0)))
        else $error("refused beat with slot or size");

    // load count stays within the table
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loaded <= CNT_W'(BLOCKS)))
        else $error("load count past table depth");

endmodule
`default_nettype wire
